@@ src/rcbh_pkg.sv @@
// ----------------------------------------------------------------------------
// rcbh_pkg - shared types and constants for the hopping link controller
// Beat structs, link phase codes, hop tables and tick wait values.
// ----------------------------------------------------------------------------
package rcbh_pkg;

   // hop table geometry
   localparam int HOP_CHANNELS = 4;
   localparam int HOP_IDX_W    = $clog2(HOP_CHANNELS);

   typedef logic [HOP_CHANNELS-1:0][7:0] hop_table_type;

   // hop tables, entry 0 in the low byte
   localparam hop_table_type RESET_TABLE = 32'h2040304b;
   localparam hop_table_type BASE_LOW    = 32'h3a2a1a0a;
   localparam hop_table_type BASE_MID    = 32'h22420a2a;
   localparam hop_table_type BASE_HIGH   = 32'h32123a1a;
   localparam hop_table_type FIXED_1E    = 32'h38184121;
   localparam hop_table_type FIXED_1F    = 32'h39194121;

   localparam logic [39:0] RESET_ADDRESS = 40'hafaeadacab;

   // packet checks
   localparam logic [7:0] SUM_OFFSET  = 8'h55;
   localparam logic [7:0] BIND_MARKER = 8'ha2;
   localparam logic [7:0] BIND_FILL   = 8'haa;
   localparam logic [4:0] SEL_MASK    = 5'h1f;

   localparam logic [5:0] MISS_LIMIT = 6'd40;

   // tick waits in microseconds
   localparam logic [14:0] WAIT_START   = 15'd500;
   localparam logic [14:0] WAIT_SCAN    = 15'd28000;
   localparam logic [14:0] WAIT_RETRY   = 15'd4000;
   localparam logic [14:0] WAIT_FRAME   = 15'd8000;
   localparam logic [14:0] WAIT_LONG    = 15'd32000;
   localparam logic [14:0] WAIT_SHORT   = 15'd250;

   // link status codes
   localparam logic [1:0] STATUS_NEW_DATA = 2'd0;
   localparam logic [1:0] STATUS_BINDING  = 2'd1;
   localparam logic [1:0] STATUS_NO_DATA  = 2'd2;

   typedef enum logic [4:0] {
      PHASE_INIT       = 5'b00001,
      PHASE_NO_BIND    = 5'b00010,
      PHASE_WAIT_FSYNC = 5'b00100,
      PHASE_BOUND      = 5'b01000,
      PHASE_LOST_BOUND = 5'b10000
   } phase_type;

   typedef struct packed {
      phase_type             phase;
      logic [5:0]            miss_count;
      logic [HOP_IDX_W-1:0]  hop_index;
      hop_table_type         hop_table;
   } link_state_type;

   typedef struct packed {
      logic        rx_ready;
      logic [63:0] payload_low;
      logic [15:0] payload_high;
   } req_payload_type;

   typedef struct packed {
      logic [14:0] wait_us;
      logic        hop;
      logic [7:0]  rf_channel;
      logic        load_address;
      logic [39:0] rx_address;
      logic        data_valid;
      logic [63:0] packet_data;
      logic [1:0]  link_status;
   } rsp_payload_type;

endpackage

@@ src/rc_receiver_bind_hop_fsm.sv @@
// ----------------------------------------------------------------------------
// rc_receiver_bind_hop_fsm - receiver link controller for a hopping RC link
// Tracks bind, sync and loss phases and issues hop, address and data beats.
//
//   channel   ports                           direction  beat
//   req       req_valid/req_ready/req_payload in         one scheduler tick
//   rsp       rsp_valid/rsp_ready/rsp_payload out        one tick result
//   csr       csr_write_enable/csr_write_data in         decode_enable write
//
// A tick beat lands in the input register, then the phase logic writes the
// result register and the link state together; one beat per cycle is
// sustained while the result register is not stalled.
// Reset is synchronous; it puts the link in the init phase with the default
// hop table. A stalled result holds its register; the input stage keeps
// taking beats while the result register is free or being drained.
// ----------------------------------------------------------------------------
module rc_receiver_bind_hop_fsm (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  rcbh_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rcbh_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_write_enable,
   input  logic                      csr_write_data
);

   logic                      in_valid_ff;
   logic                      in_valid_in;
   rcbh_pkg::req_payload_type in_item_ff;
   logic                      out_valid_ff;
   logic                      out_valid_in;
   rcbh_pkg::rsp_payload_type out_item_ff;
   rcbh_pkg::link_state_type  state_ff;
   rcbh_pkg::link_state_type  state_in;
   rcbh_pkg::rsp_payload_type step_result;
   logic                      decode_enable_ff;
   logic                      step_fire;

   // handshake control
   assign step_fire    = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || step_fire;
   assign in_valid_in  = req_valid || (in_valid_ff && !step_fire);
   assign out_valid_in = step_fire || (out_valid_ff && !rsp_ready);

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

   // phase logic
   rcbh_step u_step (
      .state         (state_ff),
      .item          (in_item_ff),
      .decode_enable (decode_enable_ff),
      .state_next    (state_in),
      .result        (step_result)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         decode_enable_ff     <= 1'b0;
         state_ff.phase       <= rcbh_pkg::PHASE_INIT;
         state_ff.miss_count  <= '0;
         state_ff.hop_index   <= '0;
         state_ff.hop_table   <= rcbh_pkg::RESET_TABLE;
      end else begin
         if (req_ready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            decode_enable_ff <= csr_write_data;
         end
         if (step_fire) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_payload;
      end
      if (step_fire) begin
         out_item_ff <= step_result;
      end
   end

   // checks
   a_no_hop_no_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.hop |-> rsp_payload.rf_channel == 8'h00)
      else $error("channel set without a hop");

   a_load_with_hop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.load_address |-> rsp_payload.hop)
      else $error("address load without a hop");

   a_data_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.data_valid
                    == (rsp_payload.link_status == rcbh_pkg::STATUS_NEW_DATA))
      else $error("data flag and status disagree");

   a_result_follows_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff))
      else $error("result beat without a tick");

endmodule

@@ src/rcbh_derive.sv @@
// ----------------------------------------------------------------------------
// rcbh_derive - hop table derivation
// Maps the five select bits of the bound address to a four-entry hop table.
// ----------------------------------------------------------------------------
module rcbh_derive (
   input  logic [4:0]             sel,
   output rcbh_pkg::hop_table_type hop_table
);

   logic [4:0]              sel_low;
   rcbh_pkg::hop_table_type tbl_low;
   rcbh_pkg::hop_table_type tbl_mid;
   rcbh_pkg::hop_table_type tbl_high;

   // candidate tables for each select range
   always_comb begin
      sel_low = (sel == 5'd6) ? 5'd7 : sel;
      for (int i = 0; i < rcbh_pkg::HOP_CHANNELS; i++) begin
         tbl_low[i]  = rcbh_pkg::BASE_LOW[i] + {3'b000, sel_low};
         tbl_mid[i]  = rcbh_pkg::BASE_MID[i] + {5'b00000, sel[2:0]};
         tbl_high[i] = rcbh_pkg::BASE_HIGH[i] + {5'b00000, sel[2:0]};
      end
      // select 0x16 bumps the first two channels
      if (sel == 5'h16) begin
         tbl_mid[0] = tbl_mid[0] + 8'd1;
         tbl_mid[1] = tbl_mid[1] + 8'd1;
      end
   end

   // range select
   always_comb begin
      if (sel inside {[5'h00:5'h0f]}) begin
         hop_table = tbl_low;
      end else if (sel inside {[5'h10:5'h17]}) begin
         hop_table = tbl_mid;
      end else if (sel inside {[5'h18:5'h1d]}) begin
         hop_table = tbl_high;
      end else if (sel == 5'h1e) begin
         hop_table = rcbh_pkg::FIXED_1E;
      end else begin
         hop_table = rcbh_pkg::FIXED_1F;
      end
   end

endmodule

@@ src/rcbh_step.sv @@
// ----------------------------------------------------------------------------
// rcbh_step - one tick of the link phase machine
// Computes the next link state and the result beat from one registered tick.
// ----------------------------------------------------------------------------
module rcbh_step (
   input  rcbh_pkg::link_state_type  state,
   input  rcbh_pkg::req_payload_type item,
   input  logic                      decode_enable,
   output rcbh_pkg::link_state_type  state_next,
   output rcbh_pkg::rsp_payload_type result
);

   logic [9:0][7:0]         pkt;
   logic [7:0]              sum_x;
   logic                    sum_ok;
   logic                    bind_ok;
   logic [39:0]             bind_addr;
   rcbh_pkg::hop_table_type bind_table;
   logic                    hop_req;

   assign pkt = {item.payload_high, item.payload_low};

   // checksum: xor of bytes 0..8 plus offset against byte 9
   always_comb begin
      sum_x = '0;
      for (int i = 0; i < 9; i++) begin
         sum_x = sum_x ^ pkt[i];
      end
      sum_ok = ((sum_x + rcbh_pkg::SUM_OFFSET) == pkt[9]);
   end

   // bind packet check and address, bytes 4..0 from low to high
   assign bind_ok = sum_ok && (pkt[0] == rcbh_pkg::BIND_MARKER)
                    && (pkt[5] == rcbh_pkg::BIND_FILL) && (pkt[6] == rcbh_pkg::BIND_FILL)
                    && (pkt[7] == rcbh_pkg::BIND_FILL) && (pkt[8] == 8'h00);
   assign bind_addr = {pkt[0], pkt[1], pkt[2], pkt[3], pkt[4]};

   rcbh_derive u_derive (
      .sel       (pkt[4][4:0] & rcbh_pkg::SEL_MASK),
      .hop_table (bind_table)
   );

   // phase machine
   always_comb begin
      state_next     = state;
      result         = '0;
      result.wait_us = rcbh_pkg::WAIT_RETRY;
      hop_req        = 1'b0;

      case (state.phase)
         rcbh_pkg::PHASE_INIT: begin
            state_next.hop_table = rcbh_pkg::RESET_TABLE;
            state_next.hop_index = '0;
            result.load_address  = 1'b1;
            result.rx_address    = rcbh_pkg::RESET_ADDRESS;
            hop_req              = 1'b1;
            state_next.phase     = rcbh_pkg::PHASE_NO_BIND;
            result.wait_us       = rcbh_pkg::WAIT_START;
         end
         rcbh_pkg::PHASE_NO_BIND: begin
            if (!item.rx_ready) begin
               hop_req        = 1'b1;
               result.wait_us = rcbh_pkg::WAIT_SCAN;
            end else if (bind_ok) begin
               result.load_address   = 1'b1;
               result.rx_address     = bind_addr;
               state_next.hop_table  = bind_table;
               state_next.hop_index  = '0;
               state_next.miss_count = '0;
               hop_req               = 1'b1;
               state_next.phase      = rcbh_pkg::PHASE_WAIT_FSYNC;
               result.wait_us        = rcbh_pkg::WAIT_START;
            end else begin
               result.wait_us = rcbh_pkg::WAIT_RETRY;
            end
         end
         rcbh_pkg::PHASE_WAIT_FSYNC: begin
            if (item.rx_ready) begin
               hop_req               = 1'b1;
               state_next.phase      = rcbh_pkg::PHASE_BOUND;
               state_next.miss_count = '0;
               result.wait_us        = rcbh_pkg::WAIT_FRAME;
            end else begin
               if (state.miss_count > rcbh_pkg::MISS_LIMIT) begin
                  state_next.phase = rcbh_pkg::PHASE_INIT;
               end
               state_next.miss_count = state.miss_count + 6'd1;
               result.wait_us        = rcbh_pkg::WAIT_LONG;
            end
         end
         rcbh_pkg::PHASE_BOUND, rcbh_pkg::PHASE_LOST_BOUND: begin
            if (state.phase == rcbh_pkg::PHASE_LOST_BOUND && !item.rx_ready) begin
               hop_req        = 1'b1;
               result.wait_us = rcbh_pkg::WAIT_LONG;
            end else if (!item.rx_ready) begin
               if (state.miss_count > rcbh_pkg::MISS_LIMIT) begin
                  state_next.miss_count = '0;
                  state_next.phase      = rcbh_pkg::PHASE_LOST_BOUND;
               end else begin
                  state_next.miss_count = state.miss_count + 6'd1;
               end
               result.wait_us = rcbh_pkg::WAIT_SHORT;
            end else begin
               state_next.phase      = rcbh_pkg::PHASE_BOUND;
               state_next.miss_count = '0;
               if (decode_enable && sum_ok && (pkt[8] == 8'h00)) begin
                  result.data_valid  = 1'b1;
                  result.packet_data = item.payload_low;
               end
               hop_req        = 1'b1;
               result.wait_us = rcbh_pkg::WAIT_FRAME;
            end
         end
         default: begin
            state_next.phase = rcbh_pkg::PHASE_INIT;
            result.wait_us   = rcbh_pkg::WAIT_RETRY;
         end
      endcase

      // hop from the (possibly just loaded) table, then advance the index
      if (hop_req) begin
         result.hop           = 1'b1;
         result.rf_channel    = state_next.hop_table[state_next.hop_index];
         state_next.hop_index = state_next.hop_index + 1'b1;
      end

      // link status
      if (result.data_valid) begin
         result.link_status = rcbh_pkg::STATUS_NEW_DATA;
      end else if (state_next.phase == rcbh_pkg::PHASE_NO_BIND
                   || state_next.phase == rcbh_pkg::PHASE_WAIT_FSYNC) begin
         result.link_status = rcbh_pkg::STATUS_BINDING;
      end else begin
         result.link_status = rcbh_pkg::STATUS_NO_DATA;
      end
   end

endmodule
